[src/sstsig_pkg.sv]
`timescale 1ns / 1ps

package sstsig_pkg;

    // Alphabet and window geometry
    localparam int unsigned ALPHA      = 26;
    localparam int unsigned GRAM       = 5;
    localparam int unsigned WIN_DEPTH  = GRAM - 1;
    localparam int unsigned LETTER_W   = 5;
    localparam int unsigned RUN_W      = 3;

    localparam logic [7:0]  UPPER_A    = 8'h41;
    localparam logic [7:0]  UPPER_Z    = 8'h5A;
    localparam logic [7:0]  LOWER_A    = 8'h61;
    localparam logic [7:0]  LOWER_Z    = 8'h7A;
    localparam logic [7:0]  CASE_SHIFT = 8'h20;

    // Bitmap geometry: bit i of the map stands for code CODE_BASE + i
    localparam int unsigned MAP_WORDS  = 275;
    localparam int unsigned WORD_W     = 64;
    localparam int unsigned BIT_W      = $clog2(WORD_W);
    localparam int unsigned ADDR_W     = $clog2(MAP_WORDS);
    localparam int unsigned CODE_W     = 15;
    localparam int unsigned COUNT_W    = 15;
    localparam int unsigned CODE_BASE  = 97;
    localparam int unsigned CODE_MAX   = 17672;

    // Stream payload widths
    localparam int unsigned S_DATA_W   = 8;
    localparam int unsigned M_DATA_W   = 32;

    // Operation codes carried in the input tuser bit
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MARK,
        ST_SCAN,
        ST_EMIT
    } state_t;

    // Binary index of a one-hot word.
    function automatic logic [BIT_W-1:0] onehot_index(input logic [WORD_W-1:0] oh);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (oh[i])
            begin
                idx = idx | BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

[src/sorted_skip_trigram_signature.sv]
`timescale 1ns / 1ps
// Result path: an end-of-text character moves its count through ST_EMIT to the output register,
// by way of ST_MARK when its letter completes a run of five; a read steps through ST_SCAN over
// empty words to ST_EMIT, or straight to ST_EMIT once the scan is past the last bitmap word.
// Throughput: one character per cycle unless it marks a code (ST_MARK read-modify-write of one
// bitmap word); a result transaction (ST_EMIT) holds the input while m_axis_tready stays low.
// Reset (rst_n low, asynchronous) clears control state, then ST_CLEAR clears all 275 bitmap words.

module sorted_skip_trigram_signature
    (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [sstsig_pkg::S_DATA_W-1:0]   s_axis_tdata,   // [7:0] char_byte
    input  logic                              s_axis_tuser,   // [0] opcode
    input  logic                              s_axis_tlast,   // end_of_text

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [sstsig_pkg::M_DATA_W-1:0]   m_axis_tdata,   // [14:0] code_out,
                                                              // [29:15] distinct_count,
                                                              // [31:30] zero
    output logic                              m_axis_tuser,   // [0] code_valid
    output logic                              m_axis_tlast    // last_code
    );

    import sstsig_pkg::*;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                state_reg,      state_next;
    logic [ADDR_W-1:0]     clr_addr_reg,   clr_addr_next;
    logic [LETTER_W-1:0]   win_reg [WIN_DEPTH];
    logic [LETTER_W-1:0]   win_next [WIN_DEPTH];
    logic [RUN_W-1:0]      run_reg,        run_next;
    logic [COUNT_W-1:0]    count_reg,      count_next;
    logic [ADDR_W-1:0]     scan_reg,       scan_next;
    logic [ADDR_W-1:0]     word_reg,       word_next;
    logic [BIT_W-1:0]      bit_reg,        bit_next;
    logic                  eot_reg,        eot_next;

    // Result waiting to be moved into the output register
    logic [CODE_W-1:0]     pend_code_reg,  pend_code_next;
    logic [COUNT_W-1:0]    pend_count_reg, pend_count_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic                  pend_last_reg,  pend_last_next;

    // Output register: holds a finished transaction while the next item is taken in
    logic                  out_valid_reg,  out_valid_next;
    logic [CODE_W-1:0]     out_code_reg,   out_code_next;
    logic [COUNT_W-1:0]    out_count_reg,  out_count_next;
    logic                  out_cv_reg,     out_cv_next;
    logic                  out_last_reg,   out_last_next;

    // ------------------------------------------------------------------
    // Bitmap RAM
    // ------------------------------------------------------------------
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [WORD_W-1:0]     ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [WORD_W-1:0]     ram_rdata;

    sstsig_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAP_WORDS)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Character decode: fold upper case onto lower case, then test range
    // ------------------------------------------------------------------
    logic [7:0]            char_lc;
    logic                  is_letter;
    logic [LETTER_W-1:0]   letter;
    logic [CODE_W-1:0]     gram_idx;
    logic                  in_accept;

    always_comb
    begin
        char_lc = s_axis_tdata;
        if (s_axis_tdata >= UPPER_A && s_axis_tdata <= UPPER_Z)
        begin
            char_lc = s_axis_tdata + CASE_SHIFT;
        end
        is_letter = (char_lc >= LOWER_A) && (char_lc <= LOWER_Z);
        letter    = LETTER_W'(char_lc - LOWER_A);
        // Skip-gram index: first, third and fifth letters of the window
        gram_idx  = CODE_W'(win_reg[0] * CODE_W'(ALPHA * ALPHA))
                  + CODE_W'(win_reg[2] * CODE_W'(ALPHA))
                  + CODE_W'(letter);
    end

    assign in_accept = s_axis_tvalid && s_axis_tready;

    // Scan helpers: isolate the lowest set bit of the word just read
    logic [WORD_W-1:0]     low_bit;
    logic [BIT_W-1:0]      low_idx;
    logic [ADDR_W-1:0]     scan_inc;

    assign low_bit  = ram_rdata & (~ram_rdata + WORD_W'(1));
    assign low_idx  = onehot_index(low_bit);
    assign scan_inc = scan_reg + ADDR_W'(1);

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        win_next        = win_reg;
        run_next        = run_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        word_next       = word_reg;
        bit_next        = bit_reg;
        eot_next        = eot_reg;
        pend_code_next  = pend_code_reg;
        pend_count_next = pend_count_reg;
        pend_valid_next = pend_valid_reg;
        pend_last_next  = pend_last_reg;

        out_valid_next  = out_valid_reg;
        out_code_next   = out_code_reg;
        out_count_next  = out_count_reg;
        out_cv_next     = out_cv_reg;
        out_last_next   = out_last_reg;

        ram_we          = 1'b0;
        ram_waddr       = word_reg;
        ram_wdata       = '0;
        ram_raddr       = scan_reg;

        s_axis_tready   = (state_reg == ST_IDLE);

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(MAP_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_axis_tuser == OP_READ)
                    begin
                        if (scan_reg >= ADDR_W'(MAP_WORDS))
                        begin
                            // Nothing left: empty read result
                            pend_code_next  = '0;
                            pend_count_next = '0;
                            pend_valid_next = 1'b0;
                            pend_last_next  = 1'b0;
                            state_next      = ST_EMIT;
                        end
                        else
                        begin
                            ram_raddr  = scan_reg;
                            state_next = ST_SCAN;
                        end
                    end
                    else
                    begin
                        eot_next = s_axis_tlast;
                        if (is_letter)
                        begin
                            if (run_reg >= RUN_W'(WIN_DEPTH))
                            begin
                                word_next  = gram_idx[CODE_W-1:BIT_W];
                                bit_next   = gram_idx[BIT_W-1:0];
                                ram_raddr  = gram_idx[CODE_W-1:BIT_W];
                                state_next = ST_MARK;
                            end
                            for (int i = 0; i < WIN_DEPTH - 1; i++)
                            begin
                                win_next[i] = win_reg[i+1];
                            end
                            win_next[WIN_DEPTH-1] = letter;
                            if (run_reg < RUN_W'(WIN_DEPTH))
                            begin
                                run_next = run_reg + RUN_W'(1);
                            end
                        end
                        else
                        begin
                            run_next = '0;
                        end

                        if (s_axis_tlast)
                        begin
                            for (int i = 0; i < WIN_DEPTH; i++)
                            begin
                                win_next[i] = '0;
                            end
                            run_next = '0;
                            if (!(is_letter && run_reg >= RUN_W'(WIN_DEPTH)))
                            begin
                                pend_code_next  = '0;
                                pend_count_next = count_reg;
                                pend_valid_next = 1'b0;
                                pend_last_next  = 1'b0;
                                state_next      = ST_EMIT;
                            end
                        end
                    end
                end
            end

            ST_MARK:
            begin
                if (!ram_rdata[bit_reg])
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = word_reg;
                    ram_wdata  = ram_rdata | (WORD_W'(1) << bit_reg);
                    count_next = count_reg + COUNT_W'(1);
                end
                if (word_reg < scan_reg)
                begin
                    scan_next = word_reg;
                end
                if (eot_reg)
                begin
                    pend_code_next  = '0;
                    pend_count_next = count_next;
                    pend_valid_next = 1'b0;
                    pend_last_next  = 1'b0;
                    state_next      = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                if (ram_rdata == '0)
                begin
                    scan_next = scan_inc;
                    if (scan_inc == ADDR_W'(MAP_WORDS))
                    begin
                        pend_code_next  = '0;
                        pend_count_next = '0;
                        pend_valid_next = 1'b0;
                        pend_last_next  = 1'b0;
                        state_next      = ST_EMIT;
                    end
                    else
                    begin
                        ram_raddr = scan_inc;
                    end
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = scan_reg;
                    ram_wdata = ram_rdata & ~low_bit;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - COUNT_W'(1);
                    end
                    pend_code_next  = {scan_reg, low_idx} + CODE_W'(CODE_BASE);
                    pend_count_next = '0;
                    pend_valid_next = 1'b1;
                    pend_last_next  = (count_next == '0);
                    state_next      = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_code_next  = pend_code_reg;
                    out_count_next = pend_count_reg;
                    out_cv_next    = pend_valid_reg;
                    out_last_next  = pend_last_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            for (int i = 0; i < WIN_DEPTH; i++)
            begin
                win_reg[i] <= '0;
            end
            run_reg       <= '0;
            count_reg     <= '0;
            scan_reg      <= '0;
            eot_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            win_reg       <= win_next;
            run_reg       <= run_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            eot_reg       <= eot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        word_reg       <= word_next;
        bit_reg        <= bit_next;
        pend_code_reg  <= pend_code_next;
        pend_count_reg <= pend_count_next;
        pend_valid_reg <= pend_valid_next;
        pend_last_reg  <= pend_last_next;
        out_code_reg   <= out_code_next;
        out_count_reg  <= out_count_next;
        out_cv_reg     <= out_cv_next;
        out_last_reg   <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_DATA_W - CODE_W - COUNT_W){1'b0}}, out_count_reg, out_code_reg};
    assign m_axis_tuser  = out_cv_reg;
    assign m_axis_tlast  = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // No item may enter while the bitmap is still being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s_axis_tready)
        else $error("item accepted during bitmap clearing pass");

    // A delivered code always lies in the signature range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            (m_axis_tdata[CODE_W-1:0] >= CODE_W'(CODE_BASE)) &&
            (m_axis_tdata[CODE_W-1:0] <= CODE_W'(CODE_MAX)))
        else $error("signature code out of range");

    // The scan pointer never passes one beyond the last bitmap word.
    assert property (@(posedge clk) disable iff (!rst_n)
        scan_reg <= ADDR_W'(MAP_WORDS))
        else $error("scan pointer beyond bitmap");

    // A code transaction with an empty map left behind must be flagged last.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && ram_rdata != '0 && count_next == '0) |=> pend_last_reg)
        else $error("final code not flagged as last");

endmodule

[src/sstsig_ram.sv]
`timescale 1ns / 1ps

module sstsig_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 275
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, single read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
